>>> design/bdeq_pkg.sv
// Shared types and command codes for the bounded double-ended queue.
package bdeq_pkg;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_PEEK      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA
  } state_t;

  localparam int CAP_W      = 11;
  localparam int VALUE_W    = 32;
  localparam int CAP_RESET  = 1024;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

endpackage

>>> design/bounded_double_ended_queue.sv
// Bounded double-ended queue: ring store in RAM with front index and count.
// An item updates front/count, the RAMs read its new ends, then the result is loaded
// (out_valid high). A new item waits for that; the RAM read of the new ends sets this.
// The next item is taken while an earlier result still waits on out_stall.
// Reset (rst_n low, synchronous): queue empty, front 0, capacity 1024, no result.
// Storage contents are not cleared; only entries written by an insert are read.
module bounded_double_ended_queue #(
  parameter int MAX_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_cmd,
  input  logic signed [bdeq_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic signed [bdeq_pkg::VALUE_W-1:0] out_front_value,
  output logic signed [bdeq_pkg::VALUE_W-1:0] out_rear_value,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdeq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bdeq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bdeq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import bdeq_pkg::*;

  // Index, count and ring arithmetic widths follow the ring depth; KW also covers CAP_W.
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  state_t state_r, state_nxt;

  logic [AW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0] capacity_r;
  logic             ok_r, ok_nxt;

  logic                      out_valid_r;
  logic                      out_ok_r;
  logic signed [VALUE_W-1:0] out_front_r;
  logic signed [VALUE_W-1:0] out_rear_r;
  logic                      out_empty_r;
  logic                      out_full_r;

  logic              accept;
  logic              load_out;
  logic              out_free;
  logic [KW-1:0]     cap_eff;
  logic [KW-1:0]     count_ext;
  logic              can_insert;
  logic              is_empty_now;
  logic              is_full_now;
  logic [SW-1:0]     rear_sum;
  logic [SW-1:0]     tail_sum;
  logic [SW-1:0]     next_sum;
  logic [AW-1:0]     tail_addr;
  logic [AW-1:0]     rear_addr;
  logic [AW-1:0]     front_inc;
  logic [AW-1:0]     front_dec;
  logic [CW-1:0]     count_m1;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VALUE_W-1:0] front_rdata;
  logic [VALUE_W-1:0] rear_rdata;

  // ---------------------------------------------------------------------------
  // Configuration: one register (capacity) at word address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(capacity_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && (paddr[APB_ADDR_W-1] == 1'b0)) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Saturate the programmed capacity to the ring depth.
  always_comb begin
    if (KW'(capacity_r) > KW'(MAX_DEPTH)) begin
      cap_eff = KW'(MAX_DEPTH);
    end else begin
      cap_eff = KW'(capacity_r);
    end
  end

  assign count_ext    = KW'(count_r);
  assign can_insert   = (count_ext < cap_eff);
  assign is_empty_now = (count_r == '0);
  assign is_full_now  = (count_ext == cap_eff);

  // ---------------------------------------------------------------------------
  // Ring arithmetic: every sum stays below twice the depth (the rear one when
  // the queue is non-empty), so one compare-and-subtract wraps it.
  // ---------------------------------------------------------------------------
  assign count_m1 = count_r - CW'(1);

  always_comb begin
    // slot just past the rear (insert rear target)
    tail_sum = SW'(front_r) + SW'(count_r);
    if (tail_sum >= SW'(MAX_DEPTH)) begin
      tail_sum = tail_sum - SW'(MAX_DEPTH);
    end
    tail_addr = tail_sum[AW-1:0];

    // current rear slot; meaningless when empty, never used then
    rear_sum = SW'(front_r) + SW'(count_m1);
    if (rear_sum >= SW'(MAX_DEPTH)) begin
      rear_sum = rear_sum - SW'(MAX_DEPTH);
    end
    rear_addr = rear_sum[AW-1:0];

    // front advanced by one
    next_sum = SW'(front_r) + SW'(1);
    if (next_sum >= SW'(MAX_DEPTH)) begin
      next_sum = next_sum - SW'(MAX_DEPTH);
    end
    front_inc = next_sum[AW-1:0];

    // front stepped back by one
    if (front_r == '0) begin
      front_dec = AW'(MAX_DEPTH - 1);
    end else begin
      front_dec = front_r - AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode at accept: update front/count, write the inserted item.
  // ---------------------------------------------------------------------------
  assign accept = in_valid && !in_stall;

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = tail_addr;
    if (accept) begin
      ok_nxt = 1'b0;
      case (in_cmd)
        CMD_INS_FRONT: begin
          if (can_insert) begin
            front_nxt = front_dec;
            wr_addr   = front_dec;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
        end
        CMD_INS_REAR: begin
          if (can_insert) begin
            wr_addr   = tail_addr;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
        end
        CMD_DEL_FRONT: begin
          if (!is_empty_now) begin
            front_nxt = front_inc;
            count_nxt = count_m1;
            ok_nxt    = 1'b1;
          end
        end
        CMD_DEL_REAR: begin
          if (!is_empty_now) begin
            count_nxt = count_m1;
            ok_nxt    = 1'b1;
          end
        end
        CMD_PEEK: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Two RAM copies take the same writes; one reads the front, one the rear.
  // Reads always follow the registered front/count, so the addresses hold
  // steady while a result waits and the read data stays valid.
  // ---------------------------------------------------------------------------
  bdeq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_DEPTH)
  ) u_front_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (front_r),
    .rdata (front_rdata)
  );

  bdeq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_DEPTH)
  ) u_rear_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (rear_addr),
    .rdata (rear_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes an item, READ presents the new end addresses,
  // DATA captures the read data into the output register once it is free.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_READ: begin
        in_stall = 1'b1;
      end
      ST_DATA: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop once taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok_r    <= ok_r;
      out_empty_r <= is_empty_now;
      out_full_r  <= is_full_now;
      if (is_empty_now) begin
        out_front_r <= -VALUE_W'(1);
        out_rear_r  <= -VALUE_W'(1);
      end else begin
        out_front_r <= front_rdata;
        out_rear_r  <= rear_rdata;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

>>> design/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/bdeq_checker.sv
// Checker for the bounded double-ended queue: predicts every result and compares it.
module bdeq_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [2:0]                          in_cmd,
  input  logic [bdeq_pkg::VALUE_W-1:0]        in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_ok,
  input  logic [bdeq_pkg::VALUE_W-1:0]        out_front_value,
  input  logic [bdeq_pkg::VALUE_W-1:0]        out_rear_value,
  input  logic                                out_is_empty,
  input  logic                                out_is_full,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [bdeq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bdeq_pkg::APB_DATA_W-1:0]     pwdata,
  output int                                  fail_count,
  output int                                  outstanding
);
  import bdeq_pkg::*;

  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [VALUE_W-1:0]    EMPTY_VALUE  = '1;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } deque_result_t;

  logic [VALUE_W-1:0] entries [DEPTH];
  int unsigned        head_idx;
  int unsigned        held;
  int unsigned        capacity;
  deque_result_t      pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic deque_result_t predict_deque_op(input logic [2:0] cmd,
                                                     input logic [VALUE_W-1:0] val);
    int unsigned   cap_eff;
    deque_result_t r;
    cap_eff = (capacity > DEPTH) ? DEPTH : capacity;
    r = '0;
    case (cmd)
      CMD_INS_FRONT: if (held < cap_eff) begin
        head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
        entries[head_idx] = val;
        held++;
        r.ok = 1'b1;
      end
      CMD_INS_REAR: if (held < cap_eff) begin
        entries[(head_idx + held) % DEPTH] = val;
        held++;
        r.ok = 1'b1;
      end
      CMD_DEL_FRONT: if (held != 0) begin
        head_idx = (head_idx + 1) % DEPTH;
        held--;
        r.ok = 1'b1;
      end
      CMD_DEL_REAR: if (held != 0) begin
        held--;
        r.ok = 1'b1;
      end
      CMD_PEEK: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    if (held == 0) begin
      r.front_value = EMPTY_VALUE;
      r.rear_value  = EMPTY_VALUE;
    end else begin
      r.front_value = entries[head_idx];
      r.rear_value  = entries[(head_idx + held - 1) % DEPTH];
    end
    r.is_empty = (held == 0);
    r.is_full  = (held == cap_eff);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t want;
    if (!rst_n) begin
      head_idx = 0;
      held     = 0;
      capacity = CAP_RESET;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // retire the oldest expectation before queuing a new one
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item pending", out_front_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ok !== want.ok)
            report_mismatch("ok", VALUE_W'(out_ok), VALUE_W'(want.ok));
          if (out_front_value !== want.front_value)
            report_mismatch("front_value", out_front_value, want.front_value);
          if (out_rear_value !== want.rear_value)
            report_mismatch("rear_value", out_rear_value, want.rear_value);
          if (out_is_empty !== want.is_empty)
            report_mismatch("is_empty", VALUE_W'(out_is_empty), VALUE_W'(want.is_empty));
          if (out_is_full !== want.is_full)
            report_mismatch("is_full", VALUE_W'(out_is_full), VALUE_W'(want.is_full));
        end
      end
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_CAPACITY)
        capacity = pwdata[CAP_W-1:0];
      if (in_valid && !in_stall)
        pending_results.push_back(predict_deque_op(in_cmd, in_value));
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> tb/sv/tb_bounded_double_ended_queue.sv
// Testbench top for the bounded double-ended queue: stimulus, receiver and verdict.
module tb_bounded_double_ended_queue;
  import bdeq_pkg::*;

  localparam int                    DEPTH       = 1024;
  localparam int                    LIMIT       = 400000;
  localparam int                    HOLD_LEN    = 400;
  localparam int                    TAIL_WAIT   = 8;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR    = 3'd0;
  // next register slot; no register lives there, so a write must change nothing
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = 3'd4;
  localparam logic [2:0]            CMD_BAD_LO  = 3'd5;
  localparam logic [2:0]            CMD_BAD_MID = 3'd6;
  localparam logic [2:0]            CMD_BAD_HI  = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            in_cmd;
  logic [VALUE_W-1:0]    in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_ok;
  logic [VALUE_W-1:0]    out_front_value;
  logic [VALUE_W-1:0]    out_rear_value;
  logic                  out_is_empty;
  logic                  out_is_full;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int cycle_cnt;
  int in_idle_pct;
  int out_stall_pct;
  int hold_cnt;
  logic hold_req;

  bounded_double_ended_queue #(.MAX_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
    .out_front_value(out_front_value), .out_rear_value(out_rear_value),
    .out_is_empty(out_is_empty), .out_is_full(out_is_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bdeq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
    .out_front_value(out_front_value), .out_rear_value(out_rear_value),
    .out_is_empty(out_is_empty), .out_is_full(out_is_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: give up if the run hangs anywhere.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so the
  // block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
      if (hold_req)
        hold_cnt <= HOLD_LEN;
    end
  end

  // Pick a value; lean on the sign extremes now and then.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Pick a command: ins_pct of 85 go to inserts, the rest of the 85 to deletes;
  // peeks and unknown codes fill the remaining share.
  function automatic logic [2:0] random_cmd(input int ins_pct);
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
    if (r < 15)
      return CMD_PEEK;
    if (r < 15 + ins_pct)
      return $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_REAR;
    return $urandom_range(1) ? CMD_DEL_FRONT : CMD_DEL_REAR;
  endfunction

  // Offer one item after a random idle gap and hold it until the block takes it.
  task automatic send_item(input logic [2:0] cmd, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every queued expectation has been matched by a result.
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [CAP_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // upper bits are junk; only the register's own bits count
    pwdata  <= {$urandom} & ~32'(2**CAP_W - 1) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random phase at a given capacity and idling mix.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int ins_pct,
                           input int idle_pct, input int stall_pct);
    wait_drained();
    cfg_write(CAP_ADDR, cap);
    in_idle_pct    = idle_pct;
    out_stall_pct <= stall_pct;
    repeat (n) send_item(random_cmd(ins_pct), random_value());
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_PEEK;
    in_value      <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    hold_req      <= 1'b0;
    out_stall_pct <= 0;
    in_idle_pct    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue at reset capacity, failing deletes, unknown codes.
    send_item(CMD_PEEK, '0);
    send_item(CMD_DEL_FRONT, '0);
    send_item(CMD_DEL_REAR, '0);
    send_item(CMD_BAD_LO, 32'h1234_5678);
    send_item(CMD_BAD_HI, '0);
    // Insert the sign extremes at both ends; the first front insert wraps the index.
    send_item(CMD_INS_FRONT, 32'h7FFF_FFFF);
    send_item(CMD_INS_REAR, 32'h8000_0000);
    send_item(CMD_INS_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_INS_REAR, 32'h0000_0000);
    send_item(CMD_BAD_MID, 32'hDEAD_BEEF);
    send_item(CMD_PEEK, 32'h5555_AAAA);
    send_item(CMD_DEL_FRONT, '0);
    send_item(CMD_DEL_REAR, '0);
    send_item(CMD_DEL_REAR, '0);
    send_item(CMD_DEL_FRONT, '0);
    in_valid <= 1'b0;

    // Capacity of one: fill, refuse, empty.
    wait_drained();
    cfg_write(CAP_ADDR, 11'd1);
    send_item(CMD_INS_REAR, 32'hA5A5_A5A5);
    send_item(CMD_INS_FRONT, 32'h0F0F_0F0F);
    send_item(CMD_INS_REAR, 32'h0F0F_0F0F);
    send_item(CMD_DEL_FRONT, '0);
    in_valid <= 1'b0;

    // Capacity of zero: reports empty and full at once, every insert refused.
    wait_drained();
    cfg_write(CAP_ADDR, 11'd0);
    send_item(CMD_INS_FRONT, 32'h1111_1111);
    send_item(CMD_INS_REAR, 32'h2222_2222);
    send_item(CMD_PEEK, '0);
    in_valid <= 1'b0;

    // Random phases: capacity, items, insert share, sender idle, receiver stall.
    run_phase(11'd8,    150, 45,  0,  0);
    run_phase(11'd1,    100, 45, 56,  0);
    run_phase(11'd16,   150, 50,  0, 56);
    run_phase(11'd3,    150, 45, 33, 33);
    // above the store size: capacity saturates; build up a deep queue
    run_phase(11'd2047, 150, 65, 56, 56);
    // lowered below the current count: inserts refused until deletes catch up
    run_phase(11'd4,    150, 20, 33, 33);
    run_phase(11'd0,     50, 45,  0,  0);

    // Pressure: long receiver hold-off while the sender keeps offering items.
    wait_drained();
    cfg_write(CAP_ADDR, 11'd1024);
    in_idle_pct    = 0;
    out_stall_pct <= 0;
    hold_req      <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (80) send_item(random_cmd(45), random_value());
    in_valid <= 1'b0;
    run_phase(11'd1024, 70, 45, 33, 33);

    // A write to the empty register slot must leave the capacity alone.
    wait_drained();
    cfg_write(SPARE_ADDR, 11'd1);
    in_idle_pct    = 33;
    out_stall_pct <= 33;
    repeat (30) send_item(random_cmd(60), random_value());
    in_valid <= 1'b0;
    run_phase(11'd2,    100, 45, 33, 33);
    run_phase(11'd1025,  70, 45,  0,  0);

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
